FILE: hw/rtl/gsa_pkg.sv
// Shared constants, codes and transaction types of the generational slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package gsa_pkg;

  localparam int SLOTS    = 256;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int GRP_SIZE = 16;
  localparam int OFF_W    = $clog2(GRP_SIZE);
  localparam int GRPS     = SLOTS / GRP_SIZE;
  localparam int GRP_W    = SLOT_W - OFF_W;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 8;
  localparam int GEN_W  = 32;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 9;
  localparam int LIM_W  = 9;
  localparam int STS_W  = 2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(256);

  // Action codes on the input channel.
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd2;

  // Status codes on the result channel.
  localparam logic [STS_W-1:0] STS_OK         = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL       = 2'd1;
  localparam logic [STS_W-1:0] STS_INVALID    = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY_FREE = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_FREE   = 2'd2,
    OP_REJECT = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  hgen;
    logic [KIND_W-1:0] kind;
    logic [LIM_W-1:0]  lim;
  } cmd_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator: front end, back end and port wiring.
//
// A table of 256 slots, each with a kind and a 32-bit generation, driven through
// queue-style ports. The front end classifies each transaction and places it in
// a two-entry command queue; the back end executes one command at a time against
// the slot memories and posts the answer into a two-entry result queue. Lookup,
// free and rejected transactions go through a memory read, then check and
// write-back; allocate passes through an extra pick state, because the lowest free slot is
// found in two steps, first its group of 16 slots and then the slot within it.
// Both queues let the input side keep pushing while a result waits to be popped.
// Occupancy and generation-written bits are flip-flops cleared by reset, so the
// block is usable straight after reset with no clearing pass.
// The limit register may be written only while the block holds no transaction.
`timescale 1ns / 1ps
`default_nettype none
module generational_slot_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [gsa_pkg::ACT_W-1:0]   in_action,
  input  wire logic [gsa_pkg::IDX_W-1:0]   in_slot_index,
  input  wire logic [gsa_pkg::GEN_W-1:0]   in_handle_generation,
  input  wire logic [gsa_pkg::KIND_W-1:0]  in_new_kind,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic      [gsa_pkg::STS_W-1:0]   out_status,
  output logic      [gsa_pkg::IDX_W-1:0]   out_result_index,
  output logic      [gsa_pkg::GEN_W-1:0]   out_result_generation,
  output logic      [gsa_pkg::KIND_W-1:0]  out_result_kind,
  output logic      [gsa_pkg::CNT_W-1:0]   out_active_count,
  input  wire logic                        cfg_we,
  input  wire logic [gsa_pkg::LIM_W-1:0]   cfg_wdata
);

  logic          cmd_valid;
  logic          cmd_pop;
  gsa_pkg::cmd_t cmd;
  gsa_pkg::res_t res;

  gsa_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_action            (in_action),
    .in_slot_index        (in_slot_index),
    .in_handle_generation (in_handle_generation),
    .in_new_kind          (in_new_kind),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop)
  );

  gsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_status            = res.status;
  assign out_result_index      = res.idx;
  assign out_result_generation = res.gen;
  assign out_result_kind       = res.kind;
  assign out_active_count      = res.count;

  // The occupied count can never exceed the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_active_count <= gsa_pkg::CNT_W'(gsa_pkg::SLOTS)))
    else $error("active count above table size");

  // A full report carries no slot information.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == gsa_pkg::STS_FULL)) |->
      ((out_result_index == '0) && (out_result_generation == '0) &&
       (out_result_kind == '0)))
    else $error("full status with non-zero payload");

  // A successful answer for an occupied slot always has a live generation.
  a_live_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == gsa_pkg::STS_OK) && (out_result_kind != '0)) |->
      (out_result_generation != '0))
    else $error("occupied slot reported with generation zero");

endmodule
`default_nettype wire

FILE: hw/rtl/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/gsa_front.sv
// Front end: limit register, input classification and the two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module gsa_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [gsa_pkg::ACT_W-1:0]   in_action,
  input  wire logic [gsa_pkg::IDX_W-1:0]   in_slot_index,
  input  wire logic [gsa_pkg::GEN_W-1:0]   in_handle_generation,
  input  wire logic [gsa_pkg::KIND_W-1:0]  in_new_kind,
  input  wire logic                        cfg_we,
  input  wire logic [gsa_pkg::LIM_W-1:0]   cfg_wdata,
  output logic                             cmd_valid,
  output gsa_pkg::cmd_t                    cmd,
  input  wire logic                        cmd_pop
);

  logic [gsa_pkg::LIM_W-1:0] limit_r;
  logic [gsa_pkg::LIM_W-1:0] lim;
  gsa_pkg::cmd_t             cls;
  gsa_pkg::cmd_t             q_r [2];
  logic                      head_r, head_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      push, pop, tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= gsa_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign lim = (limit_r > gsa_pkg::LIM_W'(gsa_pkg::SLOTS)) ?
               gsa_pkg::LIM_W'(gsa_pkg::SLOTS) : limit_r;

  // Anything that cannot touch the table is turned into a reject here, so the
  // back end only ever sees work it must carry out or a fixed answer.
  always_comb begin
    cls      = '0;
    cls.op   = gsa_pkg::OP_REJECT;
    cls.idx  = in_slot_index;
    cls.hgen = in_handle_generation;
    cls.kind = in_new_kind;
    cls.lim  = lim;
    unique case (in_action)
      gsa_pkg::ACT_ALLOC: begin
        if (in_new_kind == '0) begin
          cls.idx = '0;
        end else begin
          cls.op = gsa_pkg::OP_ALLOC;
        end
      end
      gsa_pkg::ACT_LOOKUP: begin
        if (({1'b0, in_slot_index} < lim) && (in_handle_generation != '0)) begin
          cls.op = gsa_pkg::OP_LOOKUP;
        end
      end
      gsa_pkg::ACT_FREE: begin
        cls.op = gsa_pkg::OP_FREE;
      end
      default: begin
        cls.idx = '0;
      end
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[head_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;
  assign tail      = head_r ^ cnt_r[0];

  always_comb begin
    head_nxt = head_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail] <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gsa_back.sv
// Back end: slot search, slot memories, execution sequencer and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module gsa_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire gsa_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output gsa_pkg::res_t      res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PICK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  gsa_pkg::cmd_t                  cur_r, cur_nxt;
  logic [gsa_pkg::GRP_W-1:0]      grp_r, grp_nxt;
  logic                           any_r, any_nxt;
  logic                           full_r, full_nxt;
  logic [gsa_pkg::SLOTS-1:0]      occ_r, occ_nxt;
  logic [gsa_pkg::SLOTS-1:0]      gvld_r, gvld_nxt;
  logic [gsa_pkg::CNT_W-1:0]      count_r, count_nxt;

  logic [gsa_pkg::GRPS-1:0]       grp_free;
  logic [gsa_pkg::GRP_W-1:0]      grp_sel;
  logic                           any_free;
  logic [gsa_pkg::GRP_SIZE-1:0]   grp_bits;
  logic [gsa_pkg::OFF_W-1:0]      low;
  logic [gsa_pkg::SLOT_W-1:0]     pick_idx;

  logic [gsa_pkg::SLOT_W-1:0]     rd_addr;
  logic [gsa_pkg::SLOT_W-1:0]     cur_slot;
  logic                           kind_we, gen_we;
  logic [gsa_pkg::GEN_W-1:0]      gen_wdata;
  logic [gsa_pkg::KIND_W-1:0]     kind_q, kind_rd;
  logic [gsa_pkg::GEN_W-1:0]      gen_q, gen_rd, gen_inc, gen_alloc;

  gsa_pkg::res_t                  res_new;
  logic                           res_push;
  gsa_pkg::res_t                  rq_r [2];
  logic                           rq_head_r, rq_head_nxt;
  logic [1:0]                     rq_cnt_r, rq_cnt_nxt;
  logic                           rq_pop, rq_tail;

  // Group summary and lowest free group, taken from the occupancy bitmap.
  always_comb begin
    for (int g = 0; g < gsa_pkg::GRPS; g++) begin
      grp_free[g] = ~&occ_r[g*gsa_pkg::GRP_SIZE +: gsa_pkg::GRP_SIZE];
    end
    grp_sel = '0;
    for (int g = gsa_pkg::GRPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_sel = gsa_pkg::GRP_W'(g);
      end
    end
  end

  assign any_free = |grp_free;

  // Lowest free slot inside the group chosen on the previous cycle.
  always_comb begin
    grp_bits = ~occ_r[{grp_r, {gsa_pkg::OFF_W{1'b0}}} +: gsa_pkg::GRP_SIZE];
    low      = '0;
    for (int b = gsa_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        low = gsa_pkg::OFF_W'(b);
      end
    end
  end

  assign pick_idx = {grp_r, low};
  assign cur_slot = gsa_pkg::SLOT_W'(cur_r.idx);

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = gsa_pkg::SLOT_W'(cmd.idx);
      S_PICK:  rd_addr = pick_idx;
      S_EXEC:  rd_addr = cur_slot;
      default: rd_addr = cur_slot;
    endcase
  end

  gsa_ram #(
    .WIDTH (gsa_pkg::KIND_W),
    .DEPTH (gsa_pkg::SLOTS)
  ) u_kind_ram (
    .clk   (clk),
    .we    (kind_we),
    .waddr (cur_slot),
    .wdata (cur_r.kind),
    .raddr (rd_addr),
    .rdata (kind_q)
  );

  gsa_ram #(
    .WIDTH (gsa_pkg::GEN_W),
    .DEPTH (gsa_pkg::SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (cur_slot),
    .wdata (gen_wdata),
    .raddr (rd_addr),
    .rdata (gen_q)
  );

  // A generation never written reads as zero; a free slot's kind reads as zero.
  assign gen_rd    = gvld_r[cur_slot] ? gen_q : '0;
  assign kind_rd   = occ_r[cur_slot] ? kind_q : '0;
  assign gen_inc   = ((gen_rd + 1'b1) == '0) ? gsa_pkg::GEN_W'(1) : gen_rd + 1'b1;
  assign gen_alloc = (gen_rd == '0) ? gsa_pkg::GEN_W'(1) : gen_rd;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    grp_nxt   = grp_r;
    any_nxt   = any_r;
    full_nxt  = full_r;
    occ_nxt   = occ_r;
    gvld_nxt  = gvld_r;
    count_nxt = count_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_new   = '0;
    kind_we   = 1'b0;
    gen_we    = 1'b0;
    gen_wdata = gen_rd;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && (rq_cnt_r != 2'd2)) begin
          cmd_pop   = 1'b1;
          cur_nxt   = cmd;
          grp_nxt   = grp_sel;
          any_nxt   = any_free;
          full_nxt  = 1'b0;
          state_nxt = (cmd.op == gsa_pkg::OP_ALLOC) ? S_PICK : S_EXEC;
        end
      end
      S_PICK: begin
        cur_nxt.idx = gsa_pkg::IDX_W'(pick_idx);
        full_nxt    = !any_r || ({1'b0, pick_idx} >= cur_r.lim);
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        res_push      = 1'b1;
        res_new.count = count_r;
        unique case (cur_r.op)
          gsa_pkg::OP_ALLOC: begin
            if (full_r) begin
              res_new.status = gsa_pkg::STS_FULL;
            end else begin
              kind_we            = 1'b1;
              gen_we             = 1'b1;
              gen_wdata          = gen_alloc;
              occ_nxt[cur_slot]  = 1'b1;
              gvld_nxt[cur_slot] = 1'b1;
              count_nxt          = count_r + 1'b1;
              res_new.status     = gsa_pkg::STS_OK;
              res_new.idx        = cur_r.idx;
              res_new.gen        = gen_alloc;
              res_new.kind       = cur_r.kind;
              res_new.count      = count_nxt;
            end
          end
          gsa_pkg::OP_LOOKUP: begin
            res_new.idx = cur_r.idx;
            if (gen_rd == cur_r.hgen) begin
              res_new.status = gsa_pkg::STS_OK;
              res_new.gen    = cur_r.hgen;
              res_new.kind   = kind_rd;
            end else begin
              res_new.status = gsa_pkg::STS_INVALID;
            end
          end
          gsa_pkg::OP_FREE: begin
            res_new.idx = cur_r.idx;
            if (!occ_r[cur_slot]) begin
              res_new.status = gsa_pkg::STS_EMPTY_FREE;
              res_new.gen    = gen_rd;
            end else begin
              gen_we             = 1'b1;
              gen_wdata          = gen_inc;
              occ_nxt[cur_slot]  = 1'b0;
              gvld_nxt[cur_slot] = 1'b1;
              count_nxt          = (count_r != '0) ? count_r - 1'b1 : '0;
              res_new.status     = gsa_pkg::STS_OK;
              res_new.gen        = gen_inc;
              res_new.count      = count_nxt;
            end
          end
          gsa_pkg::OP_REJECT: begin
            res_new.status = gsa_pkg::STS_INVALID;
            res_new.idx    = cur_r.idx;
          end
          default: begin
            res_new.status = gsa_pkg::STS_INVALID;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      gvld_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      gvld_r  <= gvld_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    grp_r  <= grp_nxt;
    any_r  <= any_nxt;
    full_r <= full_nxt;
  end

  // Two-entry result queue; a new transaction is only started when it has room.
  assign out_empty = (rq_cnt_r == 2'd0);
  assign res       = rq_r[rq_head_r];
  assign rq_pop    = out_pop && !out_empty;
  assign rq_tail   = rq_head_r ^ rq_cnt_r[0];

  always_comb begin
    rq_head_nxt = rq_head_r ^ rq_pop;
    rq_cnt_nxt  = rq_cnt_r + {1'b0, res_push} - {1'b0, rq_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_head_r <= 1'b0;
      rq_cnt_r  <= 2'd0;
    end else begin
      rq_head_r <= rq_head_nxt;
      rq_cnt_r  <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq_r[rq_tail] <= res_new;
    end
  end

endmodule
`default_nettype wire
